// ===== rtl/kms_pkg.sv =====
package kms_pkg;

    localparam int SIGNATURE_COUNT_DEF = 66;
    localparam int KMER_W = 32;
    localparam int CFG_IDX_W = 1;
    localparam int PAIR_W = 6;
    localparam logic [31:0] MULT_STEP = 32'd9699690;
    localparam logic [31:0] KMER_MASK_RST = 32'h00FF_FFFF;

    localparam logic CFG_PROTEIN_MODE = 1'b0;
    localparam logic CFG_KMER_MASK = 1'b1;

    localparam logic OP_RESIDUE = 1'b0;
    localparam logic OP_END_READ = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_UPDATE,
        ST_EMIT
    } state_t;

    // Bit 4 marks a valid table entry; bits 3:0 carry the residue code.
    function automatic logic [4:0] residue_lookup(input logic protein, input logic [7:0] sym);
        logic [7:0] lc;
        logic [4:0] r;
        begin
            lc = sym;
            r = 5'd0;
            if (sym >= 8'h41 && sym <= 8'h5A)
            begin
                lc = sym + 8'h20;
            end
            if (!protein)
            begin
                case (lc)
                    8'h61: r = 5'h10;
                    8'h63: r = 5'h11;
                    8'h67: r = 5'h12;
                    8'h74, 8'h75: r = 5'h13;
                    default: r = 5'h00;
                endcase
            end
            else
            begin
                case (lc)
                    8'h61, 8'h73, 8'h74: r = 5'h10;
                    8'h63: r = 5'h11;
                    8'h64, 8'h6E: r = 5'h12;
                    8'h65, 8'h71: r = 5'h13;
                    8'h66, 8'h79: r = 5'h14;
                    8'h67: r = 5'h15;
                    8'h68: r = 5'h16;
                    8'h69, 8'h76: r = 5'h17;
                    8'h6B, 8'h72: r = 5'h18;
                    8'h6C, 8'h6D: r = 5'h19;
                    8'h6F: r = 5'h1A;
                    8'h70: r = 5'h1B;
                    8'h75: r = 5'h1C;
                    8'h77: r = 5'h1D;
                    default: r = 5'h00;
                endcase
            end
            return r;
        end
    endfunction

    function automatic logic [31:0] mult_a(input int j);
        logic [31:0] a;
        begin
            a = 32'd1 + 32'(j) * MULT_STEP;
            return a;
        end
    endfunction

    // Newton iteration for the inverse of an odd number modulo 2^32.
    function automatic logic [31:0] mult_inv(input int j);
        logic [31:0] a;
        logic [31:0] x;
        begin
            a = mult_a(j);
            x = a;
            for (int k = 0; k < 5; k++)
            begin
                x = x * (32'd2 - a * x);
            end
            return x;
        end
    endfunction

endpackage

// ===== rtl/kms_cell.sv =====
module kms_cell #(
    parameter logic [31:0] MULT_A = 32'd1,
    parameter logic [31:0] MULT_INV = 32'd1
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      upd,
    input  logic                      clr,
    input  logic                      shift,
    input  logic [kms_pkg::KMER_W-1:0] kmer,
    input  logic [kms_pkg::KMER_W-1:0] kmer_mask,
    input  logic [kms_pkg::KMER_W-1:0] shift_in,
    output logic [kms_pkg::KMER_W-1:0] best_kmer
);
    import kms_pkg::*;

    logic [KMER_W-1:0] rank_reg;
    logic [KMER_W-1:0] best_rank_reg;
    logic [KMER_W-1:0] best_kmer_reg;
    logic [KMER_W-1:0] rank;

    // Multiply in the pipe cycle; the compare uses the registered product.
    assign rank = (MULT_INV * (kmer - MULT_A)) & kmer_mask;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            best_rank_reg <= '1;
            best_kmer_reg <= '0;
            rank_reg      <= '1;
        end
        else
        begin
            rank_reg <= rank;
            if (clr)
            begin
                best_rank_reg <= '1;
                best_kmer_reg <= '0;
            end
            else if (shift)
            begin
                best_kmer_reg <= shift_in;
            end
            else if (upd && rank_reg < best_rank_reg)
            begin
                best_rank_reg <= rank_reg;
                best_kmer_reg <= kmer;
            end
        end
    end

    assign best_kmer = best_kmer_reg;

endmodule

// ===== rtl/kmer_minhash_sketch_top.sv =====
// A residue transaction runs lookup with k-mer update, the registered rank multiply, then the compare in every cell.
// An end-of-read transaction emits (SIGNATURE_COUNT+1)/2 results, one per cycle when taken,
// shifted two slots at a time out of the cell chain, and clears the cells as the last pair is taken.
// A new residue is not accepted until the current one has finished its compare in every cell.
// Reset: asynchronous active low; k-mer, slots, mode and mask take their reset values.
module kmer_minhash_sketch_top #(
    parameter int SIGNATURE_COUNT = kms_pkg::SIGNATURE_COUNT_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [kms_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [kms_pkg::KMER_W-1:0]   cfg_data,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic                         op,
    input  logic [7:0]                   symbol,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [kms_pkg::PAIR_W-1:0]   slot_pair,
    output logic [kms_pkg::KMER_W-1:0]   signature_even,
    output logic [kms_pkg::KMER_W-1:0]   signature_odd,
    output logic                         last_of_read
);
    import kms_pkg::*;

    localparam int PAIRS = (SIGNATURE_COUNT + 1) / 2;
    localparam int SLOTS = 2 * PAIRS;

    state_t state_reg, state_next;
    logic protein_reg;
    logic [KMER_W-1:0] mask_reg;
    logic [KMER_W-1:0] kmer_reg, kmer_next;
    logic [1:0] phase_reg, phase_next;
    logic [PAIR_W-1:0] pair_reg, pair_next;
    logic [4:0] ent;
    logic accept, do_upd, do_shift, do_clr;
    logic [KMER_W-1:0] best [SLOTS];
    logic [KMER_W-1:0] sh_in [SLOTS];

    assign accept = in_valid && in_ready;
    assign ent = residue_lookup(protein_reg, symbol);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            protein_reg <= 1'b0;
            mask_reg    <= KMER_MASK_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_PROTEIN_MODE: protein_reg <= cfg_data[0];
                CFG_KMER_MASK:    mask_reg <= cfg_data;
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        state_next = state_reg;
        kmer_next = kmer_reg;
        phase_next = phase_reg;
        pair_next = pair_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && op == OP_END_READ)
                begin
                    state_next = ST_EMIT;
                    pair_next = '0;
                end
                else if (accept && ent[4])
                begin
                    if (protein_reg)
                        kmer_next = ((kmer_reg << 4) + KMER_W'(ent[3:0])) & mask_reg;
                    else
                        kmer_next = ((kmer_reg << 2) + KMER_W'(ent[3:0])) & mask_reg;
                    state_next = ST_UPDATE;
                    phase_next = '0;
                end
            end
            ST_UPDATE:
            begin
                phase_next = phase_reg + 2'd1;
                if (phase_reg == 2'd1)
                    state_next = ST_IDLE;
            end
            ST_EMIT:
            begin
                if (out_ready)
                begin
                    pair_next = pair_reg + 1'b1;
                    if (32'(pair_reg) == PAIRS - 1)
                    begin
                        state_next = ST_IDLE;
                        kmer_next = '0;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready = (state_reg == ST_IDLE);
        out_valid = (state_reg == ST_EMIT);
        do_upd = (state_reg == ST_UPDATE) && (phase_reg == 2'd1);
        do_shift = (state_reg == ST_EMIT) && out_ready;
        do_clr = do_shift && (32'(pair_reg) == PAIRS - 1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            kmer_reg  <= '0;
            phase_reg <= '0;
            pair_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            kmer_reg  <= kmer_next;
            phase_reg <= phase_next;
            pair_reg  <= pair_next;
        end
    end

    // Each emitted pair shifts the chain down by two slots.
    for (genvar j = 0; j < SLOTS; j++)
    begin : g_cell
        if (j + 2 < SLOTS)
        begin : g_link
            assign sh_in[j] = best[j + 2];
        end
        else
        begin : g_end
            assign sh_in[j] = '0;
        end
        if (j < SIGNATURE_COUNT)
        begin : g_real
            kms_cell #(
                .MULT_A  (mult_a(j)),
                .MULT_INV(mult_inv(j))
            ) u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .upd      (do_upd),
                .clr      (do_clr),
                .shift    (do_shift),
                .kmer     (kmer_reg),
                .kmer_mask(mask_reg),
                .shift_in (sh_in[j]),
                .best_kmer(best[j])
            );
        end
        else
        begin : g_pad
            assign best[j] = '0;
        end
    end

    assign slot_pair = pair_reg;
    assign signature_even = best[0];
    assign signature_odd = best[1];
    assign last_of_read = (32'(pair_reg) == PAIRS - 1);

    a_emit_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready) else $error("input taken during emit");
    a_pair_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (32'(slot_pair) < PAIRS)) else $error("pair index out of range");
    a_last_leaves: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && last_of_read) |=> in_ready) else $error("emit did not end");

endmodule
